>>> sv/one_key_dual_output_timer_defines.svh
// Assertion macros shared by the checker of the one-key dual-output timer.
`ifndef ONE_KEY_DUAL_OUTPUT_TIMER_DEFINES_SVH
`define ONE_KEY_DUAL_OUTPUT_TIMER_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define OKDOT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("okdot same-cycle check failed");

// Property that must hold in the cycle after its condition.
`define OKDOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("okdot next-cycle check failed");

`endif

>>> sv/okdot_pkg.sv
// Types and constants shared by the one-key dual-output timer modules.
`timescale 1ns / 1ps
package okdot_pkg;

  localparam logic [2:0] REG_OPTION      = 3'd0;
  localparam logic [2:0] REG_FIRST_DUR   = 3'd1;
  localparam logic [2:0] REG_SECOND_DUR  = 3'd2;
  localparam logic [2:0] REG_FIRST_DLY   = 3'd3;
  localparam logic [2:0] REG_SECOND_DLY  = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd5;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd6;
  localparam logic [2:0] REG_TICKS_TENTH = 3'd7;

  localparam int OPT_SWAP       = 0;
  localparam int OPT_FIRST_SND  = 1;
  localparam int OPT_FIRST_MEM  = 2;
  localparam int OPT_SECOND_SND = 3;
  localparam int OPT_SECOND_MEM = 4;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_OK   = 2'd1;
  localparam logic [1:0] BEEP_UP   = 2'd2;
  localparam logic [1:0] BEEP_FALL = 2'd3;

  localparam logic [15:0] UNLIMITED    = 16'hFFFF;
  localparam logic [15:0] UPDOWN_LIMIT = 16'd20;

  typedef struct packed {
    logic [4:0]  option_bits;
    logic [15:0] first_duration;
    logic [15:0] second_duration;
    logic [15:0] first_start_delay;
    logic [15:0] second_start_delay;
    logic [7:0]  debounce_ticks;
    logic [7:0]  long_press_ticks;
    logic [7:0]  ticks_per_tenth;
  } cfg_t;

  // Key event of one tick: which output the key toggles, if any.
  typedef struct packed {
    logic tgl_second;
    logic tgl_first;
  } ev_t;

  typedef struct packed {
    logic       first_on;
    logic       second_on;
    logic [1:0] first_beep;
    logic [1:0] second_beep;
    logic       first_save;
    logic       second_save;
  } res_t;

  typedef struct packed {
    logic        lvl;
    logic [15:0] dly;
    logic [7:0]  sub;
    logic [15:0] ten;
  } lane_st_t;

  typedef struct packed {
    lane_st_t   st;
    logic [1:0] beep;
    logic       save;
  } lane_out_t;

endpackage

>>> sv/okdot_front.sv
// Front end: press counter that turns key ticks into toggle events.
`timescale 1ns / 1ps
module okdot_front (
  input  logic          clk,
  input  logic          rst_n,
  input  okdot_pkg::cfg_t cfg,
  input  logic          take,
  input  logic          key_pressed,
  output okdot_pkg::ev_t  ev
);
  import okdot_pkg::*;

  logic [7:0] press_count_r;
  logic [7:0] press_count_nxt;
  logic [7:0] pc_inc;
  logic       tgl_long;
  logic       tgl_short;
  logic       swap;

  assign swap = cfg.option_bits[OPT_SWAP];

  always_comb begin
    pc_inc = press_count_r;
    if ((press_count_r <= cfg.long_press_ticks) && (press_count_r != 8'hFF)) begin
      pc_inc = press_count_r + 8'd1;
    end
    tgl_long  = 1'b0;
    tgl_short = 1'b0;
    if (key_pressed) begin
      press_count_nxt = pc_inc;
      tgl_long        = (pc_inc == cfg.long_press_ticks);
    end else begin
      press_count_nxt = '0;
      tgl_short       = (press_count_r > cfg.debounce_ticks) &&
                        (press_count_r < cfg.long_press_ticks);
    end
    // Without swap, a short press drives the first output and a long press the second.
    ev.tgl_first  = swap ? tgl_long : tgl_short;
    ev.tgl_second = swap ? tgl_short : tgl_long;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= '0;
    end else if (take) begin
      press_count_r <= press_count_nxt;
    end
  end

endmodule

>>> sv/okdot_evq.sv
// Two-entry event queue between the front end and the timer back end.
`timescale 1ns / 1ps
module okdot_evq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  okdot_pkg::ev_t  din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output okdot_pkg::ev_t  dout
);
  import okdot_pkg::*;

  ev_t        ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/okdot_back.sv
// Back end: applies key events, runs the delay and on-time counters, queues results.
`timescale 1ns / 1ps
module okdot_back (
  input  logic          clk,
  input  logic          rst_n,
  input  okdot_pkg::cfg_t cfg,
  input  logic          ev_empty,
  input  okdot_pkg::ev_t  ev,
  output logic          ev_pop,
  input  logic          res_pop,
  output logic          res_empty,
  output okdot_pkg::res_t res
);
  import okdot_pkg::*;

  // One output for one tick: key toggle first, then its timers.
  function automatic lane_out_t step_lane(
    input lane_st_t    s,
    input logic        first_tick,
    input logic [15:0] sdly,
    input logic        tgl,
    input logic [15:0] dur,
    input logic        snd,
    input logic        mem,
    input logic [7:0]  tpt
  );
    lane_out_t o;
    logic      big;
    logic      unl;
    big    = (dur > UPDOWN_LIMIT);
    unl    = (dur == UNLIMITED);
    o.st   = s;
    o.beep = BEEP_NONE;
    o.save = 1'b0;
    if (first_tick) begin
      o.st.dly = sdly;
    end
    if (tgl) begin
      o.st.dly = '0;
      if (o.st.lvl) begin
        o.st.lvl = 1'b0;
        if (snd && big) begin
          o.beep = BEEP_FALL;
        end
      end else begin
        o.st.lvl = 1'b1;
        if (snd) begin
          o.beep = big ? BEEP_UP : BEEP_OK;
        end
        o.st.sub = tpt;
        o.st.ten = dur;
      end
      o.save = mem && unl;
    end
    if (o.st.dly != 16'd0) begin
      o.st.dly = o.st.dly - 16'd1;
      // The start-up switch is silent when it turns the output on.
      if (o.st.dly == 16'd0) begin
        if (o.st.lvl) begin
          o.st.lvl = 1'b0;
          if (snd && big) begin
            o.beep = BEEP_FALL;
          end
        end else begin
          o.st.lvl = 1'b1;
          o.st.sub = tpt;
          o.st.ten = dur;
        end
      end
    end else if (o.st.lvl && !unl) begin
      o.st.sub = o.st.sub - 8'd1;
      if (o.st.sub == 8'd0) begin
        o.st.sub = tpt;
        o.st.ten = o.st.ten - 16'd1;
        if (o.st.ten == 16'd0) begin
          o.st.lvl = 1'b0;
          if (snd && big) begin
            o.beep = BEEP_FALL;
          end
        end
      end
    end
    return o;
  endfunction

  logic       started_r;
  lane_st_t   lane0_r;
  lane_st_t   lane1_r;
  lane_out_t  l0;
  lane_out_t  l1;
  res_t       res_nxt;

  res_t       rq_r [2];
  logic       rq_wr_r;
  logic       rq_rd_r;
  logic [1:0] rq_cnt_r;
  logic [1:0] rq_cnt_nxt;
  logic       take;
  logic       do_pop;

  assign take      = !ev_empty && (rq_cnt_r != 2'd2);
  assign ev_pop    = take;
  assign res_empty = (rq_cnt_r == 2'd0);
  assign res       = rq_r[rq_rd_r];
  assign do_pop    = res_pop && !res_empty;

  always_comb begin
    l0 = step_lane(lane0_r, !started_r, cfg.first_start_delay, ev.tgl_first,
                   cfg.first_duration, cfg.option_bits[OPT_FIRST_SND],
                   cfg.option_bits[OPT_FIRST_MEM], cfg.ticks_per_tenth);
    l1 = step_lane(lane1_r, !started_r, cfg.second_start_delay, ev.tgl_second,
                   cfg.second_duration, cfg.option_bits[OPT_SECOND_SND],
                   cfg.option_bits[OPT_SECOND_MEM], cfg.ticks_per_tenth);
    res_nxt.first_on    = l0.st.lvl;
    res_nxt.second_on   = l1.st.lvl;
    res_nxt.first_beep  = l0.beep;
    res_nxt.second_beep = l1.beep;
    res_nxt.first_save  = l0.save;
    res_nxt.second_save = l1.save;
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (take && !do_pop) begin
      rq_cnt_nxt = rq_cnt_r + 2'd1;
    end else if (do_pop && !take) begin
      rq_cnt_nxt = rq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rq_r[rq_wr_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      lane0_r   <= '0;
      lane1_r   <= '0;
      rq_wr_r   <= 1'b0;
      rq_rd_r   <= 1'b0;
      rq_cnt_r  <= '0;
    end else begin
      if (take) begin
        started_r <= 1'b1;
        lane0_r   <= l0.st;
        lane1_r   <= l1.st;
        rq_wr_r   <= !rq_wr_r;
      end
      if (do_pop) begin
        rq_rd_r <= !rq_rd_r;
      end
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

endmodule

>>> sv/one_key_dual_output_timer.sv
// Path: a transferred tick is registered in the event queue; the back end then registers its
// result in the output queue, from which it shows on the out_ ports.
// Throughput: one tick per cycle when not stalled; front end, event queue and back end each take one.
// Each side stalls on its own: two-entry queues sit between front and back and at the output.
// Reset (synchronous, rst_n low): counters, timers and queues clear,
// and the configuration registers return to their default values.
`timescale 1ns / 1ps
module one_key_dual_output_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_key_pressed,
  output logic        empty,
  input  logic        pop,
  output logic        out_first_on,
  output logic        out_second_on,
  output logic [1:0]  out_first_beep,
  output logic [1:0]  out_second_beep,
  output logic        out_first_save,
  output logic        out_second_save,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  import okdot_pkg::*;

  cfg_t cfg_r;
  ev_t  fe_ev;
  ev_t  q_ev;
  res_t res;
  logic take;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.option_bits        <= 5'd24;
      cfg_r.first_duration     <= 16'd2;
      cfg_r.second_duration    <= 16'hFFFF;
      cfg_r.first_start_delay  <= 16'd0;
      cfg_r.second_start_delay <= 16'd0;
      cfg_r.debounce_ticks     <= 8'd15;
      cfg_r.long_press_ticks   <= 8'd250;
      cfg_r.ticks_per_tenth    <= 8'd25;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OPTION:      cfg_r.option_bits        <= cfg_data[4:0];
        REG_FIRST_DUR:   cfg_r.first_duration     <= cfg_data;
        REG_SECOND_DUR:  cfg_r.second_duration    <= cfg_data;
        REG_FIRST_DLY:   cfg_r.first_start_delay  <= cfg_data;
        REG_SECOND_DLY:  cfg_r.second_start_delay <= cfg_data;
        REG_DEBOUNCE:    cfg_r.debounce_ticks     <= cfg_data[7:0];
        REG_LONG_PRESS:  cfg_r.long_press_ticks   <= cfg_data[7:0];
        REG_TICKS_TENTH: cfg_r.ticks_per_tenth    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  okdot_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .take        (take),
    .key_pressed (in_key_pressed),
    .ev          (fe_ev)
  );

  okdot_evq u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .din   (fe_ev),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_ev)
  );

  okdot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ev_empty  (q_empty),
    .ev        (q_ev),
    .ev_pop    (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_first_on    = res.first_on;
  assign out_second_on   = res.second_on;
  assign out_first_beep  = res.first_beep;
  assign out_second_beep = res.second_beep;
  assign out_first_save  = res.first_save;
  assign out_second_save = res.second_save;

endmodule

>>> sv/okdot_chk.sv
// Port-level checker for the one-key dual-output timer and its bind.
`timescale 1ns / 1ps
`include "one_key_dual_output_timer_defines.svh"
module okdot_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       out_first_on,
  input logic       out_second_on,
  input logic [1:0] out_first_beep,
  input logic [1:0] out_second_beep
);
  import okdot_pkg::*;

  // A waiting result stays until it is transferred.
  `OKDOT_ASSERT_NEXT(a_res_held, clk, rst_n, !empty && !pop, !empty)

  // Leaving reset, no result is waiting and the input side is open.
  `OKDOT_ASSERT_SAME(a_reset_empty, clk, rst_n, $rose(rst_n), empty && !full)

  // A rising beep comes with the output on, a falling beep with it off. An ok beep
  // may come with either level, since a very short on-time can end in the same tick.
  `OKDOT_ASSERT_SAME(a_first_beep_lvl, clk, rst_n, !empty,
    ((out_first_beep != BEEP_UP) || out_first_on) &&
    ((out_first_beep != BEEP_FALL) || !out_first_on))

  `OKDOT_ASSERT_SAME(a_second_beep_lvl, clk, rst_n, !empty,
    ((out_second_beep != BEEP_UP) || out_second_on) &&
    ((out_second_beep != BEEP_FALL) || !out_second_on))

endmodule

bind one_key_dual_output_timer okdot_chk u_okdot_chk (.*);
